// ----- design/bni_pkg.sv -----
package bni_pkg;

   localparam int unsigned MaxChannels = 512;
   localparam int unsigned ValueWidth = 32;
   localparam int unsigned ChanWidth  = 9;
   localparam int unsigned PosWidth   = 16;
   localparam int unsigned CountWidth = 10;
   localparam int unsigned SideWidth  = 9;
   localparam int unsigned SqrtSteps  = 25;   // radicand below 2^49
   localparam int unsigned DivSteps   = 64;   // quotient bits kept

   localparam logic [1:0] CSR_ACT_CHANNELS   = 2'd0;
   localparam logic [1:0] CSR_PLANE_SIDE     = 2'd1;
   localparam logic [1:0] CSR_PARAM_CHANNELS = 2'd2;
   localparam logic [1:0] CSR_INPUT_FORMAT   = 2'd3;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_LOAD   = 1'b1;

   localparam logic [1:0] SEL_MEAN     = 2'd0;
   localparam logic [1:0] SEL_VARIANCE = 2'd1;
   localparam logic [1:0] SEL_GAIN     = 2'd2;
   localparam logic [1:0] SEL_BIAS     = 2'd3;

   localparam logic [1:0] STATUS_DONE     = 2'd0;
   localparam logic [1:0] STATUS_STORED   = 2'd1;
   localparam logic [1:0] STATUS_MISMATCH = 2'd2;

   typedef struct packed {
      logic load;        // latch the item
      logic fetch;       // register table reads, or write the table on a load
      logic prep;        // compute d, radicand, product
      logic sqrt_step;
      logic div_init;
      logic div_step;
      logic finish;      // add bias, saturate
   } bni_cmd_type;

   typedef struct packed {
      logic is_load;
      logic mismatch;
   } bni_status_type;

endpackage

// ----- design/bni_datapath.sv -----
module bni_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  bni_pkg::bni_cmd_type     cmd,
   output bni_pkg::bni_status_type  status,
   input  logic                     item_opcode,
   input  logic [1:0]               item_select,
   input  logic [8:0]               item_channel,
   input  logic [31:0]              item_value,
   input  logic [9:0]               act_channels,
   input  logic [8:0]               plane_side,
   input  logic [9:0]               param_channels,
   input  logic                     input_format,
   output logic [31:0]              res_value,
   output logic [1:0]               res_status,
   output logic                     res_saturated,
   output logic [8:0]               res_channel
);

   localparam int unsigned AW = (bni_pkg::MaxChannels > 1) ?
                                $clog2(bni_pkg::MaxChannels) : 1;

   logic [31:0] mean_mem [bni_pkg::MaxChannels];
   logic [31:0] var_mem  [bni_pkg::MaxChannels];
   logic [31:0] gain_mem [bni_pkg::MaxChannels];
   logic [31:0] bias_mem [bni_pkg::MaxChannels];

   logic        op_ff, fmt_ff, mis_ff;
   logic [1:0]  sel_ff;
   logic [8:0]  pch_ff;
   logic [31:0] val_ff;
   logic [8:0]  chan_ff, chan_in;
   logic [15:0] pos_ff, pos_in;
   logic [31:0] mean_rd_ff, var_rd_ff, gain_rd_ff, bias_rd_ff;
   logic [63:0] prod_ff;
   logic        neg_ff;
   logic [49:0] rem_ff;     // sqrt remainder
   logic [24:0] root_ff;
   logic [49:0] rad_ff;
   logic [63:0] num_ff;
   logic [63:0] quo_ff;
   logic [25:0] drem_ff;

   logic [AW-1:0] chan_addr, load_addr;
   logic          load_in_range;

   assign chan_addr = AW'(chan_ff);
   assign load_addr = AW'(pch_ff);
   assign load_in_range = ({23'd0, pch_ff} < 32'(bni_pkg::MaxChannels));

   assign status.is_load  = op_ff;
   assign status.mismatch = mis_ff;

   // counter stepping
   logic [9:0]  nch;
   logic [8:0]  side;
   logic [16:0] plane;
   always_comb begin
      nch = act_channels;
      if (nch == 10'd0) nch = 10'd1;
      if (32'(nch) > 32'(bni_pkg::MaxChannels)) nch = 10'(bni_pkg::MaxChannels);
      side = plane_side;
      if (side == 9'd0) side = 9'd1;
      if (side > 9'd256) side = 9'd256;
      plane = 17'(side * side);
      pos_in = pos_ff + 16'd1;
      chan_in = chan_ff;
      if ({1'b0, pos_ff} + 17'd1 >= plane) begin
         pos_in = 16'd0;
         if ({1'b0, chan_ff} + 10'd1 >= nch) chan_in = 9'd0;
         else chan_in = chan_ff + 9'd1;
      end
   end

   // prep stage arithmetic
   logic signed [33:0] x_s, d_s;
   logic [32:0]        d_mag;
   logic [31:0]        g_mag;
   logic [31:0]        v_pos;
   always_comb begin
      if (fmt_ff) x_s = {{2{val_ff[15]}}, val_ff[15:0], 16'd0};
      else        x_s = {{2{val_ff[31]}}, val_ff};
      d_s   = x_s - {{2{mean_rd_ff[31]}}, mean_rd_ff};
      d_mag = d_s[33] ? 33'(-d_s) : d_s[32:0];
      g_mag = gain_rd_ff[31] ? (~gain_rd_ff + 32'd1) : gain_rd_ff;
      v_pos = var_rd_ff[31] ? 32'd0 : var_rd_ff;
   end

   // sqrt step: two bits of radicand per cycle
   logic [49:0] s_trial, s_rem;
   logic [24:0] s_root;
   always_comb begin
      s_rem   = {rem_ff[47:0], rad_ff[49:48]};
      s_trial = {23'd0, root_ff, 2'b01};
      if (s_rem >= s_trial) begin
         s_rem  = s_rem - s_trial;
         s_root = {root_ff[23:0], 1'b1};
      end else begin
         s_root = {root_ff[23:0], 1'b0};
      end
   end

   // restoring divide step, one quotient bit per cycle
   logic [25:0] d_try;
   logic [25:0] d_sub;
   always_comb begin
      d_try = {drem_ff[24:0], num_ff[63]};
      d_sub = d_try - {1'b0, root_ff};
   end

   // finish
   logic signed [65:0] r_s;
   always_comb begin
      r_s = neg_ff ? -$signed({2'b00, quo_ff}) : $signed({2'b00, quo_ff});
      r_s = r_s + {{34{bias_rd_ff[31]}}, bias_rd_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff <= '0;
         pos_ff  <= '0;
         op_ff   <= 1'b0;
         mis_ff  <= 1'b0;
      end else begin
         if (cmd.load) begin
            op_ff  <= item_opcode;
            sel_ff <= item_select;
            pch_ff <= item_channel;
            val_ff <= item_value;
            fmt_ff <= input_format;
            mis_ff <= (act_channels != param_channels);
         end
         // advance only on a normalized sample
         if (cmd.finish && op_ff == bni_pkg::OP_SAMPLE && !mis_ff) begin
            chan_ff <= chan_in;
            pos_ff  <= pos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         if (op_ff == bni_pkg::OP_LOAD) begin
            if (load_in_range) begin
               case (sel_ff)
                  bni_pkg::SEL_MEAN:     mean_mem[load_addr] <= val_ff;
                  bni_pkg::SEL_VARIANCE: var_mem[load_addr]  <= val_ff;
                  bni_pkg::SEL_GAIN:     gain_mem[load_addr] <= val_ff;
                  default:               bias_mem[load_addr] <= val_ff;
               endcase
            end
         end else begin
            mean_rd_ff <= mean_mem[chan_addr];
            var_rd_ff  <= var_mem[chan_addr];
            gain_rd_ff <= gain_mem[chan_addr];
            bias_rd_ff <= bias_mem[chan_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         prod_ff <= 64'(d_mag * {1'b0, g_mag});
         neg_ff  <= d_s[33] ^ gain_rd_ff[31];
         rad_ff  <= {2'b00, v_pos + 32'd1, 16'd0};
         rem_ff  <= '0;
         root_ff <= '0;
      end
      if (cmd.sqrt_step) begin
         rem_ff  <= s_rem;
         root_ff <= s_root;
         rad_ff  <= {rad_ff[47:0], 2'b00};
      end
      if (cmd.div_init) begin
         num_ff  <= prod_ff;
         drem_ff <= '0;
         quo_ff  <= '0;
      end
      if (cmd.div_step) begin
         num_ff <= {num_ff[62:0], 1'b0};
         if (!d_sub[25]) begin
            drem_ff <= d_sub;
            quo_ff  <= {quo_ff[62:0], 1'b1};
         end else begin
            drem_ff <= d_try;
            quo_ff  <= {quo_ff[62:0], 1'b0};
         end
      end
      if (cmd.finish) begin
         res_channel   <= '0;
         res_saturated <= 1'b0;
         res_value     <= '0;
         if (op_ff == bni_pkg::OP_LOAD) begin
            res_status <= bni_pkg::STATUS_STORED;
         end else if (mis_ff) begin
            res_status <= bni_pkg::STATUS_MISMATCH;
         end else begin
            res_status  <= bni_pkg::STATUS_DONE;
            res_channel <= chan_ff;
            if (r_s > 66'sd2147483647) begin
               res_value <= 32'h7FFF_FFFF; res_saturated <= 1'b1;
            end else if (r_s < -66'sd2147483648) begin
               res_value <= 32'h8000_0000; res_saturated <= 1'b1;
            end else begin
               res_value <= r_s[31:0];
            end
         end
      end
   end

endmodule

// ----- design/bni_controller.sv -----
module bni_controller (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   output logic                     out_valid,
   input  logic                     out_ready,
   input  bni_pkg::bni_status_type  status,
   output bni_pkg::bni_cmd_type     cmd
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_FETCH, ST_PREP, ST_SQRT, ST_DIV, ST_FINISH, ST_HOLD
   } state_type;

   state_type  state_ff;
   logic [6:0] cnt_ff;
   logic       out_valid_ff;

   assign out_valid = out_valid_ff;
   // accept while a finished result waits; its slot frees when taken
   assign in_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd = '0;
      cmd.load      = in_valid && in_ready;
      cmd.fetch     = (state_ff == ST_FETCH);
      cmd.prep      = (state_ff == ST_PREP);
      cmd.sqrt_step = (state_ff == ST_SQRT);
      cmd.div_init  = (state_ff == ST_SQRT) && (cnt_ff == 7'(bni_pkg::SqrtSteps - 1));
      cmd.div_step  = (state_ff == ST_DIV);
      cmd.finish    = (state_ff == ST_FINISH) && (!out_valid_ff || out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.finish) out_valid_ff <= 1'b1;
         else if (out_valid_ff && out_ready) out_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE:  if (in_valid && in_ready) state_ff <= ST_FETCH;
            ST_FETCH: begin
               if (status.is_load || status.mismatch) state_ff <= ST_FINISH;
               else state_ff <= ST_PREP;
            end
            ST_PREP: begin
               cnt_ff   <= '0;
               state_ff <= ST_SQRT;
            end
            ST_SQRT: begin
               if (cnt_ff == 7'(bni_pkg::SqrtSteps - 1)) begin
                  cnt_ff   <= '0;
                  state_ff <= ST_DIV;
               end else begin
                  cnt_ff <= cnt_ff + 7'd1;
               end
            end
            ST_DIV: begin
               if (cnt_ff == 7'(bni_pkg::DivSteps - 1)) state_ff <= ST_FINISH;
               else cnt_ff <= cnt_ff + 7'd1;
            end
            ST_FINISH: begin
               if (!out_valid_ff || out_ready) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// ----- design/batchnorm_inference_unit.sv -----
// Channel  Direction  Handshake              Payload
// req      in         req_tvalid/req_tready  tdata {value,param_channel,param_select,opcode}
// rsp      out        rsp_tvalid/rsp_tready  tdata {channel_used,saturated,status,result_value}
// csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// A load's result is valid after fetch and finish; a sample's after fetch, prepare,
// 25 square-root steps (two radicand bits each), 64 divide steps (one quotient
// bit each, 64-bit numerator), then bias and saturation. One item is in flight at
// a time; the next transfer is taken once the unit is idle, also while a result
// waits, and the result register holds the last result while the next item is accepted.
// Reset is synchronous and clears control state and the step, channel and position counters.
module batchnorm_inference_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // opcode[0], param_select[2:1], param_channel[11:3], value[43:12]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // result_value[31:0], status[33:32], saturated[34], channel_used[43:35]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   bni_pkg::bni_cmd_type    cmd;
   bni_pkg::bni_status_type status;

   logic [9:0] act_channels_ff, param_channels_ff;
   logic [8:0] plane_side_ff;
   logic       input_format_ff;

   logic [31:0] res_value;
   logic [1:0]  res_status;
   logic        res_saturated;
   logic [8:0]  res_channel;

   // always take register writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         act_channels_ff   <= 10'd1;
         plane_side_ff     <= 9'd1;
         param_channels_ff <= 10'd1;
         input_format_ff   <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            bni_pkg::CSR_ACT_CHANNELS:   act_channels_ff   <= csr_data[9:0];
            bni_pkg::CSR_PLANE_SIDE:     plane_side_ff     <= csr_data[8:0];
            bni_pkg::CSR_PARAM_CHANNELS: param_channels_ff <= csr_data[9:0];
            default:                     input_format_ff   <= csr_data[0];
         endcase
      end
   end

   bni_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .status    (status),
      .cmd       (cmd)
   );

   bni_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .item_opcode    (req_tdata[0]),
      .item_select    (req_tdata[2:1]),
      .item_channel   (req_tdata[11:3]),
      .item_value     (req_tdata[43:12]),
      .act_channels   (act_channels_ff),
      .plane_side     (plane_side_ff),
      .param_channels (param_channels_ff),
      .input_format   (input_format_ff),
      .res_value      (res_value),
      .res_status     (res_status),
      .res_saturated  (res_saturated),
      .res_channel    (res_channel)
   );

   assign rsp_tdata = {4'd0, res_channel, res_saturated, res_status, res_value};

endmodule

// ----- design/bni_checker.sv -----
module bni_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item accepted while busy");

   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("result without latency");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[33:32] != 2'd3)
      else $error("bad status code");

endmodule

bind batchnorm_inference_unit bni_checker u_bni_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);

// ----- bench/tb_top.sv -----
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned NumChan    = 512;
   localparam int unsigned CycleLimit = 1000000;
   localparam int unsigned DrainWait  = 150;

   typedef struct packed {
      logic [31:0] result_value;
      logic [1:0]  status;
      logic        saturated;
      logic [8:0]  channel_used;
   } bn_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   batchnorm_inference_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state: parameter tables, which entries hold data, counters, registers
   logic signed [31:0] mean_tab [NumChan];
   logic signed [31:0] var_tab  [NumChan];
   logic signed [31:0] gain_tab [NumChan];
   logic signed [31:0] bias_tab [NumChan];
   logic [3:0]         loaded   [NumChan];
   logic [8:0]         chan_now;
   logic [15:0]        pos_now;
   logic [9:0]         act_chans;
   logic [8:0]         side_reg;
   logic [9:0]         par_chans;
   logic               int_mode;

   logic [47:0]   pending_items[$];
   bn_result_type norm_results[$];

   int unsigned errors = 0;
   int unsigned cycles = 0;
   bit          steady = 1'b0;   // no idling on either side while set

   // Integer square root, one result bit per pass
   function automatic logic [63:0] root_of(input logic [63:0] n);
      logic [63:0] r;
      logic [63:0] t;
      r = '0;
      for (int b = 31; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t * t <= n) r = t;
      end
      return r;
   endfunction

   // Work out the normalized result of one sample and step the counters unless the channel counts mismatch
   function automatic bn_result_type normalize_sample(input logic [31:0] raw);
      bn_result_type        res;
      logic signed [63:0]   x, d, v, acc;
      logic [63:0]          root, dmag, gmag, quo;
      int unsigned          nch, side;
      res = '0;
      if (act_chans != par_chans) begin
         res.status = bni_pkg::STATUS_MISMATCH;
         return res;
      end
      x = int_mode ? 64'(signed'(raw[15:0])) * 65536 : 64'(signed'(raw));
      d = x - 64'(mean_tab[chan_now]);
      v = 64'(var_tab[chan_now]);
      if (v < 0) v = 0;
      root = root_of((64'(v) + 64'd1) << 16);
      dmag = d < 0 ? 64'(-d) : 64'(d);
      gmag = gain_tab[chan_now] < 0 ? 64'(-64'(gain_tab[chan_now]))
                                    : 64'(gain_tab[chan_now]);
      quo = (dmag * gmag) / root;
      acc = ((d < 0) != (gain_tab[chan_now] < 0)) ? -$signed(quo) : $signed(quo);
      acc = acc + 64'(bias_tab[chan_now]);
      res.status = bni_pkg::STATUS_DONE;
      res.channel_used = chan_now;
      if (acc > 64'sd2147483647) begin
         acc = 64'sd2147483647;
         res.saturated = 1'b1;
      end else if (acc < -64'sd2147483648) begin
         acc = -64'sd2147483648;
         res.saturated = 1'b1;
      end
      res.result_value = acc[31:0];
      nch = act_chans == 0 ? 1 : (act_chans > NumChan ? NumChan : act_chans);
      side = side_reg == 0 ? 1 : (side_reg > 256 ? 256 : side_reg);
      if (32'(pos_now) + 1 >= side * side) begin
         pos_now = '0;
         chan_now = (32'(chan_now) + 1 >= nch) ? '0 : chan_now + 1'b1;
      end else begin
         pos_now = pos_now + 1'b1;
      end
      return res;
   endfunction

   // Queue one item and its expected result
   task automatic push_item(input logic op, input logic [1:0] sel, input logic [8:0] pch,
                            input logic [31:0] val);
      bn_result_type res;
      res = '0;
      if (op == bni_pkg::OP_LOAD) begin
         case (sel)
            bni_pkg::SEL_MEAN:     mean_tab[pch] = val;
            bni_pkg::SEL_VARIANCE: var_tab[pch]  = val;
            bni_pkg::SEL_GAIN:     gain_tab[pch] = val;
            default:               bias_tab[pch] = val;
         endcase
         loaded[pch][sel] = 1'b1;
         res.status = bni_pkg::STATUS_STORED;
      end else begin
         res = normalize_sample(val);
      end
      pending_items.push_back({4'b0, val, pch, sel, op});
      norm_results.push_back(res);
   endtask

   function automatic logic [31:0] edgy_word();
      case ($urandom_range(0, 9))
         0: return 32'h0000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h8000_0000;
         3: return 32'hffff_ffff;
         4: return 32'h0000_0001;
         default: return $urandom;
      endcase
   endfunction

   // Variance mostly small so that results stay in range most of the time
   function automatic logic [31:0] param_word(input logic [1:0] sel);
      if ($urandom_range(0, 3) == 0) return edgy_word();
      case (sel)
         bni_pkg::SEL_VARIANCE: return $urandom_range(0, 32'h0010_0000);
         bni_pkg::SEL_GAIN:
            return 32'($signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000);
         default:               return $urandom;
      endcase
   endfunction

   // A sample on a channel whose parameters are incomplete gets its loads first, unless the channel counts mismatch
   task automatic push_sample(input logic [31:0] val);
      if (act_chans == par_chans) begin
         for (int s = 0; s < 4; s++) begin
            if (!loaded[chan_now][s])
               push_item(bni_pkg::OP_LOAD, 2'(s), chan_now, param_word(2'(s)));
         end
      end
      push_item(bni_pkg::OP_SAMPLE, 2'($urandom_range(0, 3)), 9'($urandom), val);
   endtask

   task automatic wait_idle();
      while (pending_items.size() != 0 || req_tvalid || norm_results.size() != 0)
         @(posedge clock);
      repeat (DrainWait) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
      case (idx)
         bni_pkg::CSR_ACT_CHANNELS:   act_chans = val[9:0];
         bni_pkg::CSR_PLANE_SIDE:     side_reg  = val[8:0];
         bni_pkg::CSR_PARAM_CHANNELS: par_chans = val[9:0];
         default:                     int_mode  = val[0];
      endcase
   endtask

   task automatic set_regs(input logic [9:0] act, input logic [8:0] side,
                           input logic [9:0] par, input logic fmt);
      wait_idle();
      write_reg(bni_pkg::CSR_ACT_CHANNELS, {$urandom} & ~32'h3ff | act);
      write_reg(bni_pkg::CSR_PLANE_SIDE, {$urandom} & ~32'h1ff | side);
      write_reg(bni_pkg::CSR_PARAM_CHANNELS, {$urandom} & ~32'h3ff | par);
      write_reg(bni_pkg::CSR_INPUT_FORMAT, {$urandom} & ~32'h1 | fmt);
   endtask

   // Stimulus: directed extremes, then random phases under shifting register settings
   initial begin
      logic [9:0] act;
      logic [8:0] side;
      foreach (loaded[i]) loaded[i] = '0;
      chan_now  = '0;
      pos_now   = '0;
      act_chans = 10'd1;
      side_reg  = 9'd1;
      par_chans = 10'd1;
      int_mode  = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // negative variance clamps to zero; largest gain and bias drive saturation
      push_item(bni_pkg::OP_LOAD, bni_pkg::SEL_MEAN, 9'd0, 32'h0000_0000);
      push_item(bni_pkg::OP_LOAD, bni_pkg::SEL_VARIANCE, 9'd0, 32'hffff_fffb);
      push_item(bni_pkg::OP_LOAD, bni_pkg::SEL_GAIN, 9'd0, 32'h7fff_ffff);
      push_item(bni_pkg::OP_LOAD, bni_pkg::SEL_BIAS, 9'd0, 32'h7fff_ffff);
      push_sample(32'h7fff_ffff);
      push_sample(32'h8000_0000);
      push_item(bni_pkg::OP_LOAD, bni_pkg::SEL_GAIN, 9'd0, 32'h8000_0000);
      push_item(bni_pkg::OP_LOAD, bni_pkg::SEL_BIAS, 9'd0, 32'h8000_0000);
      push_item(bni_pkg::OP_LOAD, bni_pkg::SEL_MEAN, 9'd0, 32'h8000_0000);
      push_item(bni_pkg::OP_LOAD, bni_pkg::SEL_VARIANCE, 9'd0, 32'h7fff_ffff);
      push_sample(32'h7fff_ffff);
      push_sample(32'h0000_0000);
      push_item(bni_pkg::OP_LOAD, bni_pkg::SEL_BIAS, 9'd511, 32'h1234_5678);
      push_item(bni_pkg::OP_LOAD, bni_pkg::SEL_MEAN, 9'd511, 32'hffff_ffff);
      // integer samples: only the low half counts
      set_regs(10'd1, 9'd1, 10'd1, 1'b1);
      push_sample(32'hdead_7fff);
      push_sample(32'h0000_8000);
      // channel count mismatch leaves the counters alone
      set_regs(10'd2, 9'd1, 10'd3, 1'b0);
      push_sample(32'h0001_0000);
      push_sample(edgy_word());

      for (int ph = 0; ph < 12; ph++) begin
         case (ph % 6)
            0: act = 10'd0;
            1: act = 10'd512;
            2: act = 10'h3ff;
            default: act = 10'($urandom_range(1, 8));
         endcase
         case (ph % 4)
            0: side = 9'd0;
            1: side = ph == 5 ? 9'd256 : 9'h1ff;
            default: side = 9'($urandom_range(1, 3));
         endcase
         if (ph % 4 == 1 && ph != 5) side = 9'($urandom_range(1, 2));
         if (ph == 9) side = 9'h1ff;
         set_regs(act, side, ($urandom_range(0, 4) == 0) ? act + 10'd1 : act,
                  1'($urandom));
         steady = (ph % 5 == 3);
         for (int k = 0; k < 32; k++) begin
            if ($urandom_range(0, 4) == 0)
               push_item(bni_pkg::OP_LOAD, 2'($urandom), 9'($urandom), edgy_word());
            else
               push_sample(edgy_word());
         end
      end

      // wait for the last results, then drain
      while (pending_items.size() != 0 || req_tvalid || norm_results.size() != 0)
         @(posedge clock);
      repeat (DrainWait) @(posedge clock);
      if (errors == 0)
         $display("[batchnorm_inference_unit] OK");
      else
         $display("[batchnorm_inference_unit] ERROR");
      $finish;
   end

   // Transfers seen at the rising edge, acted on at the falling edge
   logic req_taken = 1'b0;
   logic rsp_taken = 1'b0;
   always @(posedge clock) begin
      req_taken <= req_tvalid && req_tready;
      rsp_taken <= rsp_tvalid && rsp_tready;
   end

   // Driver: present items from the queue with random gaps between them
   int unsigned req_gap = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_taken) begin
            req_tvalid <= 1'b0;
            req_gap = steady ? 0 : $urandom_range(0, 16);
         end else if (!req_tvalid) begin
            if (req_gap != 0) begin
               req_gap--;
            end else if (pending_items.size() != 0) begin
               req_tdata  <= pending_items.pop_front();
               req_tvalid <= 1'b1;
            end
         end
      end
   end

   // Result side: stall a random number of cycles before each transfer
   int unsigned rsp_stall = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_taken || rsp_stall == 0) begin
            if (rsp_taken) rsp_stall = steady ? 0 : $urandom_range(0, 16);
            rsp_tready <= (rsp_stall == 0);
         end else begin
            rsp_stall--;
            rsp_tready <= (rsp_stall == 0);
         end
      end
   end

   // Monitor: compare every result transfer with the oldest expectation
   always @(posedge clock) begin
      bn_result_type want;
      bn_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[31:0], rsp_tdata[33:32], rsp_tdata[34], rsp_tdata[43:35]};
         if (norm_results.size() == 0) begin
            $error("result with nothing expected: %h", rsp_tdata);
            errors++;
         end else begin
            want = norm_results.pop_front();
            if (got.result_value !== want.result_value) begin
               $error("result_value expected %h actual %h", want.result_value,
                      got.result_value);
               errors++;
            end
            if (got.status !== want.status) begin
               $error("status expected %0d actual %0d", want.status, got.status);
               errors++;
            end
            if (got.saturated !== want.saturated) begin
               $error("saturated expected %0d actual %0d", want.saturated, got.saturated);
               errors++;
            end
            if (got.channel_used !== want.channel_used) begin
               $error("channel_used expected %0d actual %0d", want.channel_used,
                      got.channel_used);
               errors++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("[batchnorm_inference_unit] ERROR");
         $finish;
      end
   end

endmodule

// ----- batchnorm_inference_unit.f -----
design/bni_pkg.sv
design/bni_datapath.sv
design/bni_controller.sv
design/batchnorm_inference_unit.sv
design/bni_checker.sv
bench/tb_top.sv
